// File: rtl/core/psac_pkg.sv
// Shared types, codes and constants for the pedestrian signal audible cadence block.
// No dependencies; used by the channel interfaces and the top level.
package psac_pkg;

   localparam int SIGNALS     = 4;
   localparam int GLYPH_COUNT = 4;

   localparam int OP_W       = 2;
   localparam int DEV_W      = 2;
   localparam int GLYPH_W    = 4;
   localparam int TICK_W     = 16;
   localparam int WALK_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int SPAN_Q_W   = 13;
   localparam int SPAN_R_W   = 4;

   typedef logic [1:0]         mode_type;
   typedef logic [GLYPH_W-1:0] glyph_type;
   typedef logic [TICK_W-1:0]  tick_type;
   typedef logic [WALK_W-1:0]  walk_type;

   localparam logic [OP_W-1:0] OP_SECOND = 2'd0;
   localparam logic [OP_W-1:0] OP_FINE   = 2'd1;
   localparam logic [OP_W-1:0] OP_WALK   = 2'd2;

   localparam mode_type MODE_HAND  = 2'd0;
   localparam mode_type MODE_WALK  = 2'd1;
   localparam mode_type MODE_COUNT = 2'd2;

   localparam glyph_type GLYPH_HAND  = 4'd10;
   localparam glyph_type GLYPH_WALK  = 4'd11;
   localparam glyph_type COUNT_START = 4'd9;

   localparam logic [CSR_IDX_W-1:0] CSR_WALK_SECONDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_ON      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_SLOW     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_FAST     = 2'd3;

   localparam walk_type RST_WALK_SECONDS = 8'd5;
   localparam tick_type RST_BEEP_ON      = 16'd1311;
   localparam tick_type RST_GAP_SLOW     = 16'd16384;
   localparam tick_type RST_GAP_FAST     = 16'd820;

   localparam int RST_SPAN = 16384 - 820;
   localparam logic [SPAN_Q_W-1:0] RST_SPAN_Q = SPAN_Q_W'(RST_SPAN / 9);
   localparam logic [SPAN_R_W-1:0] RST_SPAN_R = SPAN_R_W'(RST_SPAN % 9);

   // floor(x/9) for 16-bit x: (x * 58255) >> 19
   localparam logic [TICK_W-1:0] SPAN_RECIP       = 16'd58255;
   localparam int                SPAN_RECIP_SHIFT = 19;

   // floor(x/9) for x below 81
   function automatic logic [3:0] div9_small(input logic [6:0] x);
      logic [12:0] p;
      p = 13'(x) * 13'd57;
      return p[12:9];
   endfunction

endpackage

// File: rtl/core/psac_if.sv
// Request and response channel interfaces for the cadence block.
// Depends on psac_pkg for field widths.
interface psac_req_if;
   logic                         valid;
   logic                         ready;
   logic [psac_pkg::OP_W-1:0]    operation;
   logic [psac_pkg::DEV_W-1:0]   device;

   modport source (output valid, output operation, output device, input ready);
   modport sink   (input valid, input operation, input device, output ready);
endinterface

interface psac_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [psac_pkg::GLYPH_W-1:0]   glyph_zero;
   logic [psac_pkg::GLYPH_W-1:0]   glyph_one;
   logic [psac_pkg::GLYPH_W-1:0]   glyph_two;
   logic [psac_pkg::GLYPH_W-1:0]   glyph_three;
   logic                           beeper_level;
   logic                           cadence_active;
   logic [psac_pkg::TICK_W-1:0]    current_gap;

   modport source (output valid, output glyph_zero, output glyph_one, output glyph_two,
                   output glyph_three, output beeper_level, output cadence_active,
                   output current_gap, input ready);
   modport sink   (input valid, input glyph_zero, input glyph_one, input glyph_two,
                   input glyph_three, input beeper_level, input cadence_active,
                   input current_gap, output ready);
endinterface

// File: rtl/core/pedestrian_signal_audible_cadence.sv
// Top level: four crossing signals, audible beeper cadence and glyph outputs.
// Depends on psac_pkg and the channel interfaces in psac_if.sv.
//
// Usage:
//   req_chan carries one word per event: operation (second tick, fine beeper
//   tick, walk request) and device (signal index for a walk request).
//   rsp_chan returns one word per request: four glyphs, beeper level,
//   cadence active flag and the present silent gap, all after the update.
//   csr_we/csr_index/csr_data write the four settings; write only while idle.
// Timing:
//   A word is registered on accept, then updated state and the response are
//   registered when it fires. One word per cycle sustained unless rsp stalls;
//   the state update, minimum search and gap interpolation sit in the single
//   stage between the two registers. The span quotient for the gap is
//   refreshed at each settings write.
// Reset (synchronous): all signals hand, beeper stopped, settings defaults.
// Stall: when rsp is not taken the response holds, the input register keeps
//   one more word, and req ready drops only when both are full.
module pedestrian_signal_audible_cadence (
   input  logic                              clock,
   input  logic                              reset,
   psac_req_if.sink                          req_chan,
   psac_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [psac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [psac_pkg::CSR_DATA_W-1:0]   csr_data
);

   // settings
   psac_pkg::walk_type walk_seconds_ff, walk_seconds_in;
   psac_pkg::tick_type beep_on_ff, beep_on_in;
   psac_pkg::tick_type gap_slow_ff, gap_slow_in;
   psac_pkg::tick_type gap_fast_ff, gap_fast_in;
   logic [psac_pkg::SPAN_Q_W-1:0] span_q_ff, span_q_in;
   logic [psac_pkg::SPAN_R_W-1:0] span_r_ff, span_r_in;
   psac_pkg::tick_type span;
   logic [2*psac_pkg::TICK_W-1:0] span_prod;

   // pipeline
   logic                          in_valid_ff, in_valid_in;
   logic [psac_pkg::OP_W-1:0]     in_op_ff;
   logic [psac_pkg::DEV_W-1:0]    in_dev_ff;
   logic                          out_valid_ff, out_valid_in;
   logic                          advance, fire, req_take;

   // signal state
   psac_pkg::mode_type  mode_ff   [psac_pkg::GLYPH_COUNT];
   psac_pkg::mode_type  mode_in   [psac_pkg::GLYPH_COUNT];
   psac_pkg::walk_type  remain_ff [psac_pkg::GLYPH_COUNT];
   psac_pkg::walk_type  remain_in [psac_pkg::GLYPH_COUNT];
   psac_pkg::glyph_type cd_ff     [psac_pkg::GLYPH_COUNT];
   psac_pkg::glyph_type cd_in     [psac_pkg::GLYPH_COUNT];
   psac_pkg::glyph_type glyph_in  [psac_pkg::GLYPH_COUNT];
   psac_pkg::glyph_type glyph_ff  [psac_pkg::GLYPH_COUNT];

   // beeper state
   logic               running_ff, running_in;
   logic               phase_on_ff, phase_on_in;
   psac_pkg::tick_type count_ff, count_in;
   psac_pkg::tick_type period_ff, period_in;
   psac_pkg::tick_type cnt_inc;

   // gap
   logic                walk_seen, any_count, active;
   psac_pkg::glyph_type least;
   psac_pkg::tick_type  gap, interp;
   logic [3:0]          frac;

   // response payload
   logic               beeper_ff;
   logic               active_ff;
   psac_pkg::tick_type gap_ff;

   // settings and span quotient/remainder
   always_comb begin
      walk_seconds_in = walk_seconds_ff;
      beep_on_in      = beep_on_ff;
      gap_slow_in     = gap_slow_ff;
      gap_fast_in     = gap_fast_ff;
      if (csr_we) begin
         case (csr_index)
            psac_pkg::CSR_WALK_SECONDS: walk_seconds_in = csr_data[psac_pkg::WALK_W-1:0];
            psac_pkg::CSR_BEEP_ON:      beep_on_in      = csr_data[psac_pkg::TICK_W-1:0];
            psac_pkg::CSR_GAP_SLOW:     gap_slow_in     = csr_data[psac_pkg::TICK_W-1:0];
            psac_pkg::CSR_GAP_FAST:     gap_fast_in     = csr_data[psac_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
      span      = (gap_slow_in >= gap_fast_in) ? (gap_slow_in - gap_fast_in) : '0;
      span_prod = 32'(span) * 32'(psac_pkg::SPAN_RECIP);
      span_q_in = psac_pkg::SPAN_Q_W'(span_prod >> psac_pkg::SPAN_RECIP_SHIFT);
      span_r_in = psac_pkg::SPAN_R_W'(span - 16'(span_q_in) * 16'd9);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_seconds_ff <= psac_pkg::RST_WALK_SECONDS;
         beep_on_ff      <= psac_pkg::RST_BEEP_ON;
         gap_slow_ff     <= psac_pkg::RST_GAP_SLOW;
         gap_fast_ff     <= psac_pkg::RST_GAP_FAST;
         span_q_ff       <= psac_pkg::RST_SPAN_Q;
         span_r_ff       <= psac_pkg::RST_SPAN_R;
      end else begin
         walk_seconds_ff <= walk_seconds_in;
         beep_on_ff      <= beep_on_in;
         gap_slow_ff     <= gap_slow_in;
         gap_fast_ff     <= gap_fast_in;
         span_q_ff       <= span_q_in;
         span_r_ff       <= span_r_in;
      end
   end

   // handshake
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   // signal update
   always_comb begin
      psac_pkg::walk_type rem_dec;
      for (int i = 0; i < psac_pkg::GLYPH_COUNT; i++) begin
         mode_in[i]   = mode_ff[i];
         remain_in[i] = remain_ff[i];
         cd_in[i]     = cd_ff[i];
         rem_dec      = (remain_ff[i] != '0) ? remain_ff[i] - 8'd1 : '0;
         if (i < psac_pkg::SIGNALS) begin
            case (in_op_ff)
               psac_pkg::OP_SECOND: begin
                  if (mode_ff[i] == psac_pkg::MODE_WALK) begin
                     remain_in[i] = rem_dec;
                     if (rem_dec == '0) begin
                        mode_in[i] = psac_pkg::MODE_COUNT;
                        cd_in[i]   = psac_pkg::COUNT_START;
                     end
                  end else if (mode_ff[i] == psac_pkg::MODE_COUNT) begin
                     if (cd_ff[i] != '0) begin
                        cd_in[i] = cd_ff[i] - 4'd1;
                     end else begin
                        mode_in[i] = psac_pkg::MODE_HAND;
                     end
                  end
               end
               psac_pkg::OP_WALK: begin
                  if (in_dev_ff == psac_pkg::DEV_W'(i) && mode_ff[i] == psac_pkg::MODE_HAND) begin
                     mode_in[i]   = psac_pkg::MODE_WALK;
                     remain_in[i] = walk_seconds_ff;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // gap from the updated signals
   always_comb begin
      walk_seen = 1'b0;
      any_count = 1'b0;
      least     = psac_pkg::COUNT_START;
      for (int i = 0; i < psac_pkg::GLYPH_COUNT; i++) begin
         glyph_in[i] = psac_pkg::GLYPH_HAND;
         if (i < psac_pkg::SIGNALS) begin
            if (mode_in[i] == psac_pkg::MODE_WALK) begin
               walk_seen   = 1'b1;
               glyph_in[i] = psac_pkg::GLYPH_WALK;
            end else if (mode_in[i] == psac_pkg::MODE_COUNT) begin
               any_count   = 1'b1;
               glyph_in[i] = cd_in[i];
               if (cd_in[i] < least) begin
                  least = cd_in[i];
               end
            end
         end
      end
      active = walk_seen || any_count;
      frac   = psac_pkg::div9_small(7'(least) * 7'(span_r_ff));
      interp = gap_fast_ff + 16'(17'(least) * 17'(span_q_ff)) + 16'(frac);
      if (!active) begin
         gap = '0;
      end else if (!any_count) begin
         gap = gap_slow_ff;
      end else begin
         gap = interp;
      end
   end

   // beeper
   always_comb begin
      running_in  = running_ff;
      phase_on_in = phase_on_ff;
      count_in    = count_ff;
      period_in   = period_ff;
      cnt_inc     = count_ff + 16'd1;
      case (in_op_ff)
         psac_pkg::OP_SECOND: begin
            if (!active) begin
               running_in  = 1'b0;
               phase_on_in = 1'b0;
               count_in    = '0;
            end else if (!running_ff) begin
               running_in  = 1'b1;
               phase_on_in = 1'b0;
               count_in    = '0;
               period_in   = gap;
            end
         end
         psac_pkg::OP_FINE: begin
            if (running_ff) begin
               if (cnt_inc < period_ff) begin
                  count_in = cnt_inc;
               end else begin
                  count_in = '0;
                  if (!active) begin
                     running_in  = 1'b0;
                     phase_on_in = 1'b0;
                  end else if (phase_on_ff) begin
                     phase_on_in = 1'b0;
                     period_in   = gap;
                  end else begin
                     phase_on_in = 1'b1;
                     period_in   = beep_on_ff;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         running_ff   <= 1'b0;
         phase_on_ff  <= 1'b0;
         count_ff     <= '0;
         period_ff    <= psac_pkg::RST_GAP_SLOW;
         for (int i = 0; i < psac_pkg::GLYPH_COUNT; i++) begin
            mode_ff[i]   <= psac_pkg::MODE_HAND;
            remain_ff[i] <= '0;
            cd_ff[i]     <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            running_ff  <= running_in;
            phase_on_ff <= phase_on_in;
            count_ff    <= count_in;
            period_ff   <= period_in;
            for (int i = 0; i < psac_pkg::GLYPH_COUNT; i++) begin
               mode_ff[i]   <= mode_in[i];
               remain_ff[i] <= remain_in[i];
               cd_ff[i]     <= cd_in[i];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_chan.operation;
         in_dev_ff <= req_chan.device;
      end
      if (fire) begin
         for (int i = 0; i < psac_pkg::GLYPH_COUNT; i++) begin
            glyph_ff[i] <= glyph_in[i];
         end
         beeper_ff <= running_in && phase_on_in;
         active_ff <= active;
         gap_ff    <= gap;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.glyph_zero     = glyph_ff[0];
   assign rsp_chan.glyph_one      = glyph_ff[1];
   assign rsp_chan.glyph_two      = glyph_ff[2];
   assign rsp_chan.glyph_three    = glyph_ff[3];
   assign rsp_chan.beeper_level   = beeper_ff;
   assign rsp_chan.cadence_active = active_ff;
   assign rsp_chan.current_gap    = gap_ff;

`ifndef SYNTHESIS
   a_stopped_is_clear: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (count_ff == '0) && !phase_on_ff)
      else $error("stopped beeper holds a phase or count");

   a_count_in_phase: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (count_ff < period_ff) || (count_ff == '0))
      else $error("phase count passed its period");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.cadence_active
         |-> !rsp_chan.beeper_level && (rsp_chan.current_gap == '0))
      else $error("beeper or gap present with no active signal");
`endif

endmodule

// File: tb/pedestrian_signal_audible_cadence_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for pedestrian_signal_audible_cadence: signal glyphs and beeper cadence.
// Drives request words from a queue and checks every response against a built-in predictor.
// Depends on psac_pkg, psac_req_if/psac_rsp_if and the block itself.
module pedestrian_signal_audible_cadence_tb;

   localparam logic [psac_pkg::OP_W-1:0] OP_NONE = 2'd3;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [psac_pkg::OP_W-1:0]  op;
      logic [psac_pkg::DEV_W-1:0] dev;
   } crossing_event_type;

   typedef struct packed {
      psac_pkg::glyph_type [psac_pkg::SIGNALS-1:0] glyph;
      logic                                        beep;
      logic                                        active;
      psac_pkg::tick_type                          gap;
   } crossing_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [psac_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [psac_pkg::CSR_DATA_W-1:0] csr_data = '0;

   psac_req_if req_bus ();
   psac_rsp_if rsp_bus ();

   pedestrian_signal_audible_cadence uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   crossing_event_type pending_events[$];
   crossing_view_type  due_views[$];
   int words_sent = 0;
   int words_accepted = 0;
   int views_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // predictor settings and state
   psac_pkg::walk_type cfg_walk;
   psac_pkg::tick_type cfg_beep, cfg_slow, cfg_fast;
   psac_pkg::mode_type lamp_mode [psac_pkg::SIGNALS];
   psac_pkg::walk_type walk_left [psac_pkg::SIGNALS];
   logic [3:0] count_digit [psac_pkg::SIGNALS];
   logic horn_run, horn_loud;
   psac_pkg::tick_type horn_ticks, horn_limit;

   function automatic logic silent_gap(output psac_pkg::tick_type gap);
      logic walking, counting;
      int unsigned least, span;
      int i;
      walking = 1'b0;
      counting = 1'b0;
      least = psac_pkg::COUNT_START;
      for (i = 0; i < psac_pkg::SIGNALS; i++) begin
         if (lamp_mode[i] == psac_pkg::MODE_WALK) begin
            walking = 1'b1;
         end else if (lamp_mode[i] == psac_pkg::MODE_COUNT) begin
            counting = 1'b1;
            if (count_digit[i] < least) least = count_digit[i];
         end
      end
      if (!walking && !counting) begin
         gap = '0;
         return 1'b0;
      end
      if (!counting) begin
         gap = cfg_slow;
         return 1'b1;
      end
      span = (cfg_slow >= cfg_fast) ? cfg_slow - cfg_fast : 0;
      gap = psac_pkg::tick_type'(cfg_fast + (span * least) / psac_pkg::COUNT_START);
      return 1'b1;
   endfunction

   function automatic crossing_view_type advance_crossing(
         input logic [psac_pkg::OP_W-1:0] op, input logic [psac_pkg::DEV_W-1:0] dev);
      crossing_view_type v;
      psac_pkg::tick_type gap;
      logic live;
      int i;
      case (op)
         psac_pkg::OP_SECOND: begin
            for (i = 0; i < psac_pkg::SIGNALS; i++) begin
               if (lamp_mode[i] == psac_pkg::MODE_WALK) begin
                  if (walk_left[i] != 0) walk_left[i]--;
                  if (walk_left[i] == 0) begin
                     lamp_mode[i] = psac_pkg::MODE_COUNT;
                     count_digit[i] = psac_pkg::COUNT_START;
                  end
               end else if (lamp_mode[i] == psac_pkg::MODE_COUNT) begin
                  if (count_digit[i] != 0) count_digit[i]--;
                  else lamp_mode[i] = psac_pkg::MODE_HAND;
               end
            end
            live = silent_gap(gap);
            if (!live) begin
               horn_run = 1'b0;
               horn_loud = 1'b0;
               horn_ticks = '0;
            end else if (!horn_run) begin
               horn_run = 1'b1;
               horn_loud = 1'b0;
               horn_ticks = '0;
               horn_limit = gap;
            end
         end
         psac_pkg::OP_FINE: begin
            if (horn_run) begin
               horn_ticks++;
               if (horn_ticks >= horn_limit) begin
                  horn_ticks = '0;
                  live = silent_gap(gap);
                  if (!live) begin
                     horn_run = 1'b0;
                     horn_loud = 1'b0;
                  end else if (horn_loud) begin
                     horn_loud = 1'b0;
                     horn_limit = gap;
                  end else begin
                     horn_loud = 1'b1;
                     horn_limit = cfg_beep;
                  end
               end
            end
         end
         psac_pkg::OP_WALK: begin
            if (dev < psac_pkg::SIGNALS && lamp_mode[dev] == psac_pkg::MODE_HAND) begin
               lamp_mode[dev] = psac_pkg::MODE_WALK;
               walk_left[dev] = cfg_walk;
            end
         end
         default: ;
      endcase
      for (i = 0; i < psac_pkg::SIGNALS; i++) begin
         if (lamp_mode[i] == psac_pkg::MODE_WALK) v.glyph[i] = psac_pkg::GLYPH_WALK;
         else if (lamp_mode[i] == psac_pkg::MODE_COUNT) v.glyph[i] = count_digit[i];
         else v.glyph[i] = psac_pkg::GLYPH_HAND;
      end
      v.active = silent_gap(gap);
      v.gap = gap;
      v.beep = horn_run && horn_loud;
      return v;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d got %0d", $time, label, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      crossing_event_type word;
      logic quiet;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            due_views.push_back(advance_crossing(req_bus.operation, req_bus.device));
            words_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            quiet = words_accepted >= 800 && words_accepted < 1000;
            if (pending_events.size() != 0 && (quiet || $urandom_range(99) >= 32)) begin
               word = pending_events.pop_front();
               words_sent++;
               req_bus.valid <= 1'b1;
               req_bus.operation <= word.op;
               req_bus.device <= word.dev;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : take_rsp
      crossing_view_type want, got;
      int hold_left;
      int i;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.glyph[0] = rsp_bus.glyph_zero;
            got.glyph[1] = rsp_bus.glyph_one;
            got.glyph[2] = rsp_bus.glyph_two;
            got.glyph[3] = rsp_bus.glyph_three;
            got.beep = rsp_bus.beeper_level;
            got.active = rsp_bus.cadence_active;
            got.gap = rsp_bus.current_gap;
            views_seen++;
            if (due_views.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none got %h", $time, got);
            end else begin
               want = due_views.pop_front();
               for (i = 0; i < psac_pkg::SIGNALS; i++)
                  check_field($sformatf("glyph %0d", i), want.glyph[i], got.glyph[i]);
               check_field("beeper_level", want.beep, got.beep);
               check_field("cadence_active", want.active, got.active);
               check_field("current_gap", want.gap, got.gap);
            end
            if (views_seen == 60) hold_left = 90;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (views_seen >= 800 && views_seen < 1000) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 32);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pedestrian_signal_audible_cadence_tb NOT OK");
         $finish;
      end
   end

   task automatic queue_event(input logic [psac_pkg::OP_W-1:0] op,
                              input logic [psac_pkg::DEV_W-1:0] dev);
      crossing_event_type e;
      e.op = op;
      e.dev = dev;
      pending_events.push_back(e);
   endtask

   task automatic queue_traffic(input int count);
      int n, pick;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 58) queue_event(psac_pkg::OP_FINE, 2'($urandom));
         else if (pick < 77) queue_event(psac_pkg::OP_SECOND, 2'($urandom));
         else if (pick < 95) queue_event(psac_pkg::OP_WALK, 2'($urandom));
         else queue_event(OP_NONE, 2'($urandom));
      end
   endtask

   task automatic settle();
      do @(posedge clock);
      while (pending_events.size() != 0 || req_bus.valid || due_views.size() != 0 ||
             words_sent != views_seen);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_setting(input logic [psac_pkg::CSR_IDX_W-1:0] index,
                                input logic [psac_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      case (index)
         psac_pkg::CSR_WALK_SECONDS: cfg_walk = data[psac_pkg::WALK_W-1:0];
         psac_pkg::CSR_BEEP_ON:      cfg_beep = data;
         psac_pkg::CSR_GAP_SLOW:     cfg_slow = data;
         psac_pkg::CSR_GAP_FAST:     cfg_fast = data;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input psac_pkg::walk_type walk, input psac_pkg::tick_type beep,
                                 input psac_pkg::tick_type slow, input psac_pkg::tick_type fast);
      settle();
      write_setting(psac_pkg::CSR_WALK_SECONDS, {8'($urandom), walk});
      write_setting(psac_pkg::CSR_BEEP_ON, beep);
      write_setting(psac_pkg::CSR_GAP_SLOW, slow);
      write_setting(psac_pkg::CSR_GAP_FAST, fast);
      @(posedge clock);
      csr_we <= 1'b0;
      repeat (4) @(posedge clock);
   endtask

   initial begin : run_crossing
      int i;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_NONE;
      req_bus.device = '0;
      rsp_bus.ready = 1'b0;
      cfg_walk = psac_pkg::RST_WALK_SECONDS;
      cfg_beep = psac_pkg::RST_BEEP_ON;
      cfg_slow = psac_pkg::RST_GAP_SLOW;
      cfg_fast = psac_pkg::RST_GAP_FAST;
      for (i = 0; i < psac_pkg::SIGNALS; i++) begin
         lamp_mode[i] = psac_pkg::MODE_HAND;
         walk_left[i] = '0;
         count_digit[i] = '0;
      end
      horn_run = 1'b0;
      horn_loud = 1'b0;
      horn_ticks = '0;
      horn_limit = psac_pkg::RST_GAP_SLOW;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // idle block, then a walk, a repeated request and a stopped beeper
      queue_event(OP_NONE, 2'd2);
      queue_event(psac_pkg::OP_SECOND, 2'd1);
      queue_event(psac_pkg::OP_FINE, 2'd3);
      queue_event(psac_pkg::OP_WALK, 2'd0);
      queue_event(psac_pkg::OP_WALK, 2'd0);
      queue_event(psac_pkg::OP_FINE, 2'd0);

      // zero walk time, zero beep length, slow gap under fast gap
      apply_settings(8'd0, 16'd0, 16'd3, 16'd6);
      queue_event(psac_pkg::OP_WALK, 2'd1);
      queue_event(psac_pkg::OP_WALK, 2'd2);
      queue_event(psac_pkg::OP_WALK, 2'd3);
      queue_event(psac_pkg::OP_FINE, 2'd1);
      queue_event(psac_pkg::OP_SECOND, 2'd0);
      for (i = 0; i < 8; i++) queue_event(psac_pkg::OP_FINE, 2'(i));
      queue_event(psac_pkg::OP_SECOND, 2'd2);
      queue_event(psac_pkg::OP_WALK, 2'd1);
      queue_event(psac_pkg::OP_FINE, 2'd3);
      queue_event(OP_NONE, 2'd1);

      apply_settings(8'd2, 16'd3, 16'd12, 16'd4);
      queue_traffic(300);
      apply_settings(8'd0, 16'd0, 16'd0, 16'd0);
      queue_traffic(150);
      apply_settings(8'd1, 16'd1, 16'd9, 16'd1);
      queue_traffic(200);
      apply_settings(8'd255, 16'd65535, 16'd65535, 16'd65535);
      queue_traffic(120);
      apply_settings(8'd3, 16'd2, 16'd3, 16'd20);
      queue_traffic(200);
      apply_settings(8'd0, 16'd1, 16'd1, 16'd1);
      queue_traffic(150);
      apply_settings(8'd1, 16'd4, 16'd65535, 16'd0);
      queue_traffic(150);
      apply_settings(8'd7, 16'd5, 16'd40, 16'd2);
      queue_traffic(380);

      settle();
      repeat (6) @(posedge clock);
      if (mismatches == 0 && due_views.size() == 0) begin
         $display("pedestrian_signal_audible_cadence_tb OK");
      end else begin
         $display("pedestrian_signal_audible_cadence_tb NOT OK");
      end
      $finish;
   end

endmodule
